// ===== rtl/core/batch_load_deframer_defines.svh =====
// ---------------------------------------------------------------------------
// batch_load_deframer_defines.svh
// Assertion macros for the batch load deframer.
// ---------------------------------------------------------------------------
`ifndef BATCH_LOAD_DEFRAMER_DEFINES_SVH
`define BATCH_LOAD_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
// check under reset as well
`define BLD_ASSERT(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
// check only outside reset
`define BLD_ASSERT_RUN(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`else
`define BLD_ASSERT(lbl, clk, prop, msg)
`define BLD_ASSERT_RUN(lbl, clk, rst, prop, msg)
`endif
`endif

// ===== rtl/core/bld_pkg.sv =====
// ---------------------------------------------------------------------------
// bld_pkg
// Shared types and constants of the batch load deframer.
// ---------------------------------------------------------------------------
`default_nettype none
package bld_pkg;

   localparam int MAX_BLOCKS_DEF    = 128;
   localparam int MAX_BLOCK_LEN_DEF = 65536;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_WRITE  = 2'd0;
   localparam logic [1:0] KIND_DESC   = 2'd1;
   localparam logic [1:0] KIND_ACCEPT = 2'd2;
   localparam logic [1:0] KIND_REJECT = 2'd3;

   localparam logic [1:0] CSR_DEST_BASE    = 2'd0;
   localparam logic [1:0] CSR_TOTAL_LEN    = 2'd1;
   localparam logic [1:0] CSR_SCRATCH_BASE = 2'd2;
   localparam logic [1:0] CSR_SCRATCH_LEN  = 2'd3;

   typedef struct packed {
      logic [1:0]  out_kind;
      logic [31:0] mem_addr;
      logic [7:0]  mem_data;
      logic [31:0] blk_src;
      logic [16:0] blk_wire_len;
      logic [31:0] blk_dst;
      logic [16:0] blk_raw_len;
      logic [6:0]  blk_index;
      logic        load_done;
      logic        last;
   } rsp_type;

   // one accepted item: one result, or a write followed by a descriptor
   typedef struct packed {
      logic    two;
      rsp_type r0;
      rsp_type r1;
   } entry_type;

endpackage
`default_nettype wire

// ===== rtl/core/batch_load_deframer.sv =====
// ---------------------------------------------------------------------------
// batch_load_deframer
// Batched load stream parser emitting memory writes, descriptors, verdicts.
// ---------------------------------------------------------------------------
//  channel  dir  handshake              payload
//  req      in   req_valid/req_ready    req_type, req_rx_byte
//  rsp      out  rsp_valid/rsp_ready    rsp_out_kind .. rsp_last
//  csr      in   csr_wr_en              csr_index, csr_wdata
//
//  One byte is parsed per cycle while the queue is not full; each result is
//  registered in the queue. A byte ending a stored compressed block gives two
//  results, a write and then a descriptor, which share one entry of the two-entry queue.
//  Synchronous reset clears all framing state and the queue.
//  req_ready drops only while the queue is full.
// ---------------------------------------------------------------------------
`default_nettype none
`include "batch_load_deframer_defines.svh"
module batch_load_deframer #(
   parameter int MAX_BLOCKS    = bld_pkg::MAX_BLOCKS_DEF,
   parameter int MAX_BLOCK_LEN = bld_pkg::MAX_BLOCK_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_type,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_out_kind,
   output logic [31:0] rsp_mem_addr,
   output logic [7:0]  rsp_mem_data,
   output logic [31:0] rsp_blk_src,
   output logic [16:0] rsp_blk_wire_len,
   output logic [31:0] rsp_blk_dst,
   output logic [16:0] rsp_blk_raw_len,
   output logic [6:0]  rsp_blk_index,
   output logic        rsp_load_done,
   output logic        rsp_last
);

   logic               push, pop, q_full, q_empty;
   bld_pkg::entry_type push_entry, head;
   bld_pkg::rsp_type   rsp;

   assign req_ready = !q_full;

   bld_front #(
      .MAX_BLOCKS    (MAX_BLOCKS),
      .MAX_BLOCK_LEN (MAX_BLOCK_LEN)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_type    (req_type),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .push        (push),
      .push_entry  (push_entry)
   );

   bld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (head)
   );

   bld_back u_back (
      .clock     (clock),
      .reset     (reset),
      .empty     (q_empty),
      .head      (head),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp       (rsp),
      .pop       (pop)
   );

   assign rsp_out_kind     = rsp.out_kind;
   assign rsp_mem_addr     = rsp.mem_addr;
   assign rsp_mem_data     = rsp.mem_data;
   assign rsp_blk_src      = rsp.blk_src;
   assign rsp_blk_wire_len = rsp.blk_wire_len;
   assign rsp_blk_dst      = rsp.blk_dst;
   assign rsp_blk_raw_len  = rsp.blk_raw_len;
   assign rsp_blk_index    = rsp.blk_index;
   assign rsp_load_done    = rsp.load_done;
   assign rsp_last         = rsp.last;

   `BLD_ASSERT(a_reset_empty, clock, reset |=> !rsp_valid, "results after reset")
   `BLD_ASSERT_RUN(a_empty_ready, clock, reset, !rsp_valid |-> req_ready,
                   "stall with empty queue")
   `BLD_ASSERT_RUN(a_verdict_last, clock, reset,
                   (rsp_valid && (rsp_out_kind == bld_pkg::KIND_ACCEPT ||
                                  rsp_out_kind == bld_pkg::KIND_REJECT)) |-> rsp_last,
                   "verdict not last")
   `BLD_ASSERT_RUN(a_desc_last, clock, reset,
                   (rsp_valid && rsp_out_kind == bld_pkg::KIND_DESC) |-> rsp_last,
                   "descriptor not last")

endmodule
`default_nettype wire

// ===== rtl/core/bld_front.sv =====
// ---------------------------------------------------------------------------
// bld_front
// Byte parser: tracks the batch framing, checks limits and builds results.
// ---------------------------------------------------------------------------
`default_nettype none
module bld_front #(
   parameter int MAX_BLOCKS    = bld_pkg::MAX_BLOCKS_DEF,
   parameter int MAX_BLOCK_LEN = bld_pkg::MAX_BLOCK_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata,
   input  logic                req_valid,
   input  logic                req_type,
   input  logic [7:0]          req_rx_byte,
   input  logic                q_full,
   output logic                push,
   output bld_pkg::entry_type  push_entry
);

   localparam int BW = $clog2(MAX_BLOCK_LEN + 1);
   localparam int CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [33:0] OFF_CAP = 34'h1_0000_0000;

   typedef enum logic [2:0] {
      PH_IDLE, PH_TYPE, PH_WLEN, PH_RLEN, PH_DATA, PH_SUM, PH_DRAIN
   } phase_type;

   typedef enum logic [1:0] {BT_OTHER, BT_U, BT_C} btype_type;

   logic [31:0] dest_base_ff, total_len_ff, scratch_base_ff, scratch_len_ff;

   phase_type   phase_ff, phase_in;
   logic [BW-1:0] bc_ff, bc_in, bc_inc;
   btype_type   btype_ff, btype_in;
   logic [31:0] wire_ff, wire_in, raw_ff, raw_in;
   logic [32:0] dest_ff, dest_in, commit_ff, commit_in, scr_ff, scr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic        ok_ff, ok_in;
   logic [31:0] rsum_ff, rsum_in, rcv_ff, rcv_in;

   logic        fire, do_type, do_header, finish;
   logic        have_w, have_d, have_v, v_acc;
   logic [31:0] shifted, raw_new, rcv_new, raw_eff, wbase;
   logic [33:0] dend, dsum, send;
   logic [32:0] commit_eff;
   bld_pkg::rsp_type res_w, res_d, res_v;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_base_ff    <= '0;
         total_len_ff    <= '0;
         scratch_base_ff <= '0;
         scratch_len_ff  <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            bld_pkg::CSR_DEST_BASE:    dest_base_ff    <= csr_wdata;
            bld_pkg::CSR_TOTAL_LEN:    total_len_ff    <= csr_wdata;
            bld_pkg::CSR_SCRATCH_BASE: scratch_base_ff <= csr_wdata;
            bld_pkg::CSR_SCRATCH_LEN:  scratch_len_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      fire    = req_valid && !q_full;
      shifted = 32'(req_rx_byte) << {bc_ff[1:0], 3'b000};
      raw_new = raw_ff | shifted;
      rcv_new = rcv_ff | shifted;
      bc_inc  = bc_ff + BW'(1);

      phase_in = phase_ff;  bc_in = bc_ff;      btype_in = btype_ff;
      wire_in  = wire_ff;   raw_in = raw_ff;    dest_in = dest_ff;
      commit_in = commit_ff; scr_in = scr_ff;   cnt_in = cnt_ff;
      ok_in    = ok_ff;     rsum_in = rsum_ff;  rcv_in = rcv_ff;

      do_type = 1'b0; do_header = 1'b0; finish = 1'b0;
      have_w = 1'b0;  have_d = 1'b0;    have_v = 1'b0; v_acc = 1'b0;
      raw_eff = raw_ff;

      if (fire) begin
         if (req_type) begin
            if (phase_ff == PH_DRAIN) begin
               have_v   = 1'b1;
               phase_in = PH_IDLE;
            end
         end else begin
            case (phase_ff)
               PH_IDLE: begin
                  // start a batch only while the load is not complete
                  if (commit_ff < {1'b0, total_len_ff}) begin
                     dest_in = commit_ff;
                     scr_in  = '0;
                     cnt_in  = '0;
                     ok_in   = 1'b1;
                     rsum_in = '0;
                     do_type = 1'b1;
                  end
               end
               PH_TYPE: do_type = 1'b1;
               PH_WLEN: begin
                  wire_in = wire_ff | shifted;
                  bc_in   = bc_inc;
                  if (bc_ff[1:0] == 2'd3) begin
                     bc_in    = '0;
                     phase_in = PH_RLEN;
                  end
               end
               PH_RLEN: begin
                  raw_in  = raw_new;
                  raw_eff = raw_new;
                  bc_in   = bc_inc;
                  if (bc_ff[1:0] == 2'd3)
                     do_header = 1'b1;
               end
               PH_DATA: begin
                  rsum_in = rsum_ff + 32'(req_rx_byte);
                  have_w  = ok_ff;
                  bc_in   = bc_inc;
                  if (32'(bc_inc) >= wire_ff)
                     finish = 1'b1;
               end
               PH_SUM: begin
                  rcv_in = rcv_new;
                  bc_in  = bc_inc;
                  if (bc_ff[1:0] == 2'd3) begin
                     have_v   = 1'b1;
                     v_acc    = ok_ff && (rcv_new == rsum_ff);
                     phase_in = PH_IDLE;
                  end
               end
               PH_DRAIN: ;
               default: phase_in = PH_IDLE;
            endcase
         end
      end

      if (do_type) begin
         bc_in = '0;
         if (req_rx_byte == 8'h45) begin
            rcv_in   = '0;
            phase_in = PH_SUM;
         end else begin
            btype_in = (req_rx_byte == 8'h55) ? BT_U :
                       (req_rx_byte == 8'h43) ? BT_C : BT_OTHER;
            wire_in  = '0;
            raw_in   = '0;
            phase_in = PH_WLEN;
         end
      end

      dend = {1'b0, dest_ff} + {2'b00, raw_new};
      send = {1'b0, scr_ff} + {2'b00, wire_ff};
      if (do_header) begin
         if (wire_ff > 32'(MAX_BLOCK_LEN) || raw_new > 32'(MAX_BLOCK_LEN) ||
             btype_ff == BT_OTHER) begin
            ok_in    = 1'b0;
            phase_in = PH_DRAIN;
         end else begin
            if (btype_ff == BT_U) begin
               if (wire_ff != raw_new || dend > {2'b00, total_len_ff})
                  ok_in = 1'b0;
            end else begin
               if (cnt_ff >= CW'(MAX_BLOCKS) || send > {2'b00, scratch_len_ff} ||
                   dend > {2'b00, total_len_ff})
                  ok_in = 1'b0;
            end
            bc_in = '0;
            if (wire_ff == '0)
               finish = 1'b1;
            else
               phase_in = PH_DATA;
         end
      end

      dsum = {1'b0, dest_ff} + {2'b00, raw_eff};
      if (finish) begin
         if (btype_ff == BT_C && ok_in) begin
            have_d = 1'b1;
            scr_in = send[32:0];
            cnt_in = cnt_ff + CW'(1);
         end
         dest_in  = (dsum > OFF_CAP) ? OFF_CAP[32:0] : dsum[32:0];
         phase_in = PH_TYPE;
      end

      commit_eff = v_acc ? dest_ff : commit_ff;
      if (have_v)
         commit_in = commit_eff;
   end

   always_comb begin
      wbase = (btype_ff == BT_U) ? dest_base_ff + dest_ff[31:0]
                                 : scratch_base_ff + scr_ff[31:0];

      res_w          = '0;
      res_w.out_kind = bld_pkg::KIND_WRITE;
      res_w.mem_addr = wbase + 32'(bc_ff);
      res_w.mem_data = req_rx_byte;

      res_d              = '0;
      res_d.out_kind     = bld_pkg::KIND_DESC;
      res_d.blk_src      = scratch_base_ff + scr_ff[31:0];
      res_d.blk_wire_len = wire_ff[16:0];
      res_d.blk_dst      = dest_base_ff + dest_ff[31:0];
      res_d.blk_raw_len  = raw_eff[16:0];
      res_d.blk_index    = 7'(32'(cnt_ff));
      res_d.last         = 1'b1;

      res_v           = '0;
      res_v.out_kind  = v_acc ? bld_pkg::KIND_ACCEPT : bld_pkg::KIND_REJECT;
      res_v.load_done = commit_eff >= {1'b0, total_len_ff};
      res_v.last      = 1'b1;

      push_entry.two = have_w && have_d;
      push_entry.r1  = res_d;
      if (have_w) begin
         push_entry.r0      = res_w;
         push_entry.r0.last = !have_d;
      end else if (have_d) begin
         push_entry.r0 = res_d;
      end else begin
         push_entry.r0 = res_v;
      end
      push = have_w || have_d || have_v;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         bc_ff     <= '0;
         btype_ff  <= BT_OTHER;
         wire_ff   <= '0;
         raw_ff    <= '0;
         dest_ff   <= '0;
         commit_ff <= '0;
         scr_ff    <= '0;
         cnt_ff    <= '0;
         ok_ff     <= 1'b1;
         rsum_ff   <= '0;
         rcv_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         bc_ff     <= bc_in;
         btype_ff  <= btype_in;
         wire_ff   <= wire_in;
         raw_ff    <= raw_in;
         dest_ff   <= dest_in;
         commit_ff <= commit_in;
         scr_ff    <= scr_in;
         cnt_ff    <= cnt_in;
         ok_ff     <= ok_in;
         rsum_ff   <= rsum_in;
         rcv_ff    <= rcv_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/bld_queue.sv =====
// ---------------------------------------------------------------------------
// bld_queue
// Short queue of parsed entries between the parser and the result stage.
// ---------------------------------------------------------------------------
`default_nettype none
module bld_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bld_pkg::entry_type push_entry,
   input  logic               pop,
   output logic               full,
   output logic               empty,
   output bld_pkg::entry_type head
);

   bld_pkg::entry_type mem [bld_pkg::QUEUE_DEPTH];

   logic [bld_pkg::QPTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [bld_pkg::QCNT_W-1:0] cnt_ff, cnt_in;

   assign full  = cnt_ff == bld_pkg::QCNT_W'(bld_pkg::QUEUE_DEPTH);
   assign empty = cnt_ff == '0;
   assign head  = mem[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + bld_pkg::QPTR_W'(1) : wr_ff;
      rd_in  = pop  ? rd_ff + bld_pkg::QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + bld_pkg::QCNT_W'(push) - bld_pkg::QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push)
         mem[wr_ff] <= push_entry;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/bld_back.sv =====
// ---------------------------------------------------------------------------
// bld_back
// Result stage: presents queued results one transfer at a time.
// ---------------------------------------------------------------------------
`default_nettype none
module bld_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               empty,
   input  bld_pkg::entry_type head,
   input  logic               rsp_ready,
   output logic               rsp_valid,
   output bld_pkg::rsp_type   rsp,
   output logic               pop
);

   logic sel_ff, sel_in;

   always_comb begin
      rsp_valid = !empty;
      rsp       = sel_ff ? head.r1 : head.r0;
      // retire the entry after its final result is transferred
      pop       = rsp_valid && rsp_ready && (sel_ff || !head.two);
      sel_in    = sel_ff;
      if (rsp_valid && rsp_ready)
         sel_in = !pop;
   end

   always_ff @(posedge clock) begin
      if (reset)
         sel_ff <= 1'b0;
      else
         sel_ff <= sel_in;
   end

endmodule
`default_nettype wire

// ===== tb/batch_load_deframer_tb.sv =====
// ---------------------------------------------------------------------------
// batch_load_deframer_tb
// Streams batched load frames into the deframer and checks its result stream.
// A model of the parser runs on every accepted byte or quiet event. It builds
// the writes, descriptors and verdicts that the block should emit, and each
// result transfer is checked field by field against them, in order.
// ---------------------------------------------------------------------------
`default_nettype none
module batch_load_deframer_tb;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [63:0] OFF_CAP = 64'h1_0000_0000;
   localparam logic [7:0] CH_U = 8'h55, CH_C = 8'h43, CH_E = 8'h45;

   typedef enum logic [2:0] {
      PH_IDLE, PH_TYPE, PH_WLEN, PH_RLEN, PH_DATA, PH_SUM, PH_DRAIN
   } parse_phase_type;
   typedef enum logic [1:0] {BT_OTHER, BT_U, BT_C} blk_kind_type;

   typedef struct packed {
      logic       quiet;
      logic [7:0] rx;
   } rx_item_type;

   logic        clock, reset;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [31:0] csr_wdata;
   logic        req_valid, req_ready, req_type;
   logic [7:0]  req_rx_byte;
   logic        rsp_valid, rsp_ready;
   bld_pkg::rsp_type got;

   batch_load_deframer u_dut (
      .clock(clock), .reset(reset),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_type(req_type), .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_out_kind(got.out_kind), .rsp_mem_addr(got.mem_addr),
      .rsp_mem_data(got.mem_data), .rsp_blk_src(got.blk_src),
      .rsp_blk_wire_len(got.blk_wire_len), .rsp_blk_dst(got.blk_dst),
      .rsp_blk_raw_len(got.blk_raw_len), .rsp_blk_index(got.blk_index),
      .rsp_load_done(got.load_done), .rsp_last(got.last)
   );

   rx_item_type      rx_stream_q[$];
   bld_pkg::rsp_type due_rsp_q[$];
   int               errors = 0;

   // parser model state and register copy
   logic [31:0]  m_dest_base = '0, m_total_len = '0, m_scr_base = '0, m_scr_len = '0;
   parse_phase_type m_ph = PH_IDLE;
   logic [31:0]  m_cnt = '0, m_wlen = '0, m_rlen = '0, m_bcnt = '0;
   blk_kind_type m_bt = BT_OTHER;
   logic [63:0]  m_doff = '0, m_coff = '0, m_soff = '0;
   logic         m_ok = 1'b1;
   logic [31:0]  m_sum = '0, m_rxsum = '0;
   bld_pkg::rsp_type pend[2];
   int           npend;

   function automatic void emit(logic [1:0] kind);
      if (npend >= 2) npend = 1;
      pend[npend] = '0;
      pend[npend].out_kind = kind;
      npend++;
   endfunction

   function automatic void close_block();
      logic [63:0] d;
      if (m_bt == BT_C && m_ok) begin
         emit(bld_pkg::KIND_DESC);
         pend[npend-1].blk_src      = m_scr_base + m_soff[31:0];
         pend[npend-1].blk_wire_len = m_wlen[16:0];
         pend[npend-1].blk_dst      = m_dest_base + m_doff[31:0];
         pend[npend-1].blk_raw_len  = m_rlen[16:0];
         pend[npend-1].blk_index    = m_bcnt[6:0];
         m_soff += m_wlen;
         m_bcnt++;
      end
      d = m_doff + m_rlen;
      m_doff = d > OFF_CAP ? OFF_CAP : d;
      m_ph = PH_TYPE;
   endfunction

   function automatic void give_verdict(logic acc);
      if (acc) m_coff = m_doff;
      emit(acc ? bld_pkg::KIND_ACCEPT : bld_pkg::KIND_REJECT);
      pend[npend-1].load_done = m_coff >= {32'd0, m_total_len};
      m_ph = PH_IDLE;
   endfunction

   function automatic void take_type(logic [7:0] b);
      m_cnt = 0;
      if (b == CH_E) begin
         m_rxsum = 0;
         m_ph = PH_SUM;
      end else begin
         m_bt = b == CH_U ? BT_U : (b == CH_C ? BT_C : BT_OTHER);
         m_wlen = 0;
         m_rlen = 0;
         m_ph = PH_WLEN;
      end
   endfunction

   function automatic void end_header();
      logic [63:0] dend;
      dend = m_doff + m_rlen;
      if (m_wlen > bld_pkg::MAX_BLOCK_LEN_DEF || m_rlen > bld_pkg::MAX_BLOCK_LEN_DEF ||
          m_bt == BT_OTHER) begin
         m_ok = 1'b0;
         m_ph = PH_DRAIN;
         return;
      end
      if (m_bt == BT_U) begin
         if (m_wlen != m_rlen || dend > {32'd0, m_total_len}) m_ok = 1'b0;
      end else if (m_bcnt >= bld_pkg::MAX_BLOCKS_DEF ||
                   m_soff + m_wlen > {32'd0, m_scr_len} ||
                   dend > {32'd0, m_total_len}) begin
         m_ok = 1'b0;
      end
      m_cnt = 0;
      if (m_wlen == 0) close_block();
      else m_ph = PH_DATA;
   endfunction

   // advance the parser by one transfer and queue what it emits
   function automatic void deframe_item(logic quiet, logic [7:0] b);
      int sh;
      logic [63:0] base;
      npend = 0;
      sh = m_cnt[1:0] * 8;
      if (quiet) begin
         if (m_ph == PH_DRAIN) give_verdict(1'b0);
      end else begin
         case (m_ph)
            PH_TYPE: take_type(b);
            PH_WLEN: begin
               m_wlen |= 32'(b) << sh;
               m_cnt++;
               if (m_cnt >= 4) begin
                  m_cnt = 0;
                  m_ph = PH_RLEN;
               end
            end
            PH_RLEN: begin
               m_rlen |= 32'(b) << sh;
               m_cnt++;
               if (m_cnt >= 4) end_header();
            end
            PH_DATA: begin
               m_sum += b;
               if (m_ok) begin
                  base = m_bt == BT_U ? m_dest_base + m_doff : m_scr_base + m_soff;
                  emit(bld_pkg::KIND_WRITE);
                  pend[npend-1].mem_addr = base[31:0] + m_cnt;
                  pend[npend-1].mem_data = b;
               end
               m_cnt++;
               if (m_cnt >= m_wlen) close_block();
            end
            PH_SUM: begin
               m_rxsum |= 32'(b) << sh;
               m_cnt++;
               if (m_cnt >= 4) give_verdict(m_ok && m_rxsum == m_sum);
            end
            PH_DRAIN: ;
            default: begin
               m_ph = PH_IDLE;
               if (m_coff < {32'd0, m_total_len}) begin
                  m_doff = m_coff;
                  m_soff = 0;
                  m_bcnt = 0;
                  m_ok = 1'b1;
                  m_sum = 0;
                  take_type(b);
               end
            end
         endcase
      end
      if (npend > 0) pend[npend-1].last = 1'b1;
      for (int i = 0; i < npend; i++) due_rsp_q.push_back(pend[i]);
   endfunction

   // clock and reset
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // sender
   int  gap = 0, burst_left = 0;
   bit  no_gaps = 1'b0;

   always @(posedge clock) begin
      logic        nv;
      rx_item_type it;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         nv = req_valid;
         if (req_valid && req_ready) begin
            deframe_item(req_type, req_rx_byte);
            nv = 1'b0;
            if (burst_left == 0) begin
               no_gaps = ($urandom_range(0, 3) == 0);
               burst_left = $urandom_range(50, 250);
            end
            burst_left--;
            if (no_gaps) gap = 0;
            else if ($urandom_range(0, 29) == 0) gap = $urandom_range(10, 40);
            else gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0;
         end
         if (!nv) begin
            if (gap > 0) begin
               gap--;
            end else if (rx_stream_q.size() > 0) begin
               it = rx_stream_q.pop_front();
               req_type <= it.quiet;
               req_rx_byte <= it.rx;
               nv = 1'b1;
            end
         end
         req_valid <= nv;
      end
   end

   // receiver
   bit long_hold_req = 1'b0;
   bit long_hold_done = 1'b0;
   int hold = 0, stall = 0;

   always @(posedge clock) begin
      logic r;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (long_hold_req && !long_hold_done) begin
            long_hold_done = 1'b1;
            hold = 400;
         end
         if (hold > 0) begin
            hold--;
            r = 1'b0;
         end else if (stall > 0) begin
            stall--;
            r = 1'b0;
         end else begin
            r = 1'b1;
            if (!no_gaps && $urandom_range(0, 7) == 0)
               stall = $urandom_range(0, 19) == 0 ? $urandom_range(10, 40)
                                                  : $urandom_range(1, 3);
         end
         rsp_ready <= r;
      end
   end

   // result checker
   always @(posedge clock) begin
      bld_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (due_rsp_q.size() == 0) begin
            $error("unexpected result, kind %0d", got.out_kind);
            errors++;
         end else begin
            want = due_rsp_q.pop_front();
            if (got !== want) begin
               errors++;
               if (got.out_kind !== want.out_kind)
                  $error("out_kind exp %0d got %0d", want.out_kind, got.out_kind);
               if (got.mem_addr !== want.mem_addr)
                  $error("mem_addr exp %h got %h", want.mem_addr, got.mem_addr);
               if (got.mem_data !== want.mem_data)
                  $error("mem_data exp %h got %h", want.mem_data, got.mem_data);
               if (got.blk_src !== want.blk_src)
                  $error("blk_src exp %h got %h", want.blk_src, got.blk_src);
               if (got.blk_wire_len !== want.blk_wire_len)
                  $error("blk_wire_len exp %0d got %0d", want.blk_wire_len, got.blk_wire_len);
               if (got.blk_dst !== want.blk_dst)
                  $error("blk_dst exp %h got %h", want.blk_dst, got.blk_dst);
               if (got.blk_raw_len !== want.blk_raw_len)
                  $error("blk_raw_len exp %0d got %0d", want.blk_raw_len, got.blk_raw_len);
               if (got.blk_index !== want.blk_index)
                  $error("blk_index exp %0d got %0d", want.blk_index, got.blk_index);
               if (got.load_done !== want.load_done)
                  $error("load_done exp %0d got %0d", want.load_done, got.load_done);
               if (got.last !== want.last)
                  $error("last exp %0d got %0d", want.last, got.last);
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // stimulus
   logic [31:0] stim_sum;

   task automatic put(logic quiet, logic [7:0] b);
      rx_stream_q.push_back('{quiet: quiet, rx: b});
   endtask

   task automatic put_word(logic [31:0] w);
      for (int i = 0; i < 4; i++) put(1'b0, w[8*i +: 8]);
   endtask

   task automatic put_block(logic [7:0] kind, logic [31:0] wl, logic [31:0] rl, bit payload);
      logic [7:0] b;
      put(1'b0, kind);
      put_word(wl);
      put_word(rl);
      if (payload) begin
         for (int i = 0; i < wl; i++) begin
            b = 8'($urandom);
            stim_sum += b;
            put(1'b0, b);
         end
      end
   endtask

   task automatic put_close(bit corrupt);
      put(1'b0, CH_E);
      put_word(corrupt ? stim_sum ^ (32'd1 << $urandom_range(0, 31)) : stim_sum);
   endtask

   // broken header: drop until a quiet event
   task automatic put_drain();
      int n;
      n = $urandom_range(0, 5);
      for (int i = 0; i < n; i++) put(1'($urandom_range(0, 1)), 8'($urandom));
      put(1'b1, 8'($urandom));
   endtask

   task automatic gen_batch();
      int nb, k, w;
      logic [7:0] t;
      stim_sum = 0;
      if ($urandom_range(0, 5) == 0) put(1'b1, 8'($urandom));
      nb = $urandom_range(0, 4);
      for (int i = 0; i < nb; i++) begin
         k = $urandom_range(0, 99);
         w = $urandom_range(0, 6);
         if (k < 45) begin
            put_block(CH_U, w, w, 1'b1);
         end else if (k < 80) begin
            put_block(CH_C, w, $urandom_range(0, 9) == 0 ? 65536 : $urandom_range(0, 64),
                      1'b1);
         end else if (k < 87) begin
            put_block(CH_U, w, w + 1, 1'b1);
         end else begin
            if ($urandom_range(0, 1)) begin
               do t = 8'($urandom); while (t == CH_U || t == CH_C || t == CH_E);
               put_block(t, w, w, 1'b0);
            end else if ($urandom_range(0, 1)) begin
               put_block($urandom_range(0, 1) ? CH_U : CH_C, 65537, w, 1'b0);
            end else begin
               put_block($urandom_range(0, 1) ? CH_U : CH_C, w, $urandom | 32'h0002_0000,
                         1'b0);
            end
            put_drain();
            return;
         end
      end
      put_close($urandom_range(0, 9) == 0);
   endtask

   task automatic gen_random(int n);
      int target;
      target = rx_stream_q.size() + n;
      while (rx_stream_q.size() < target) gen_batch();
   endtask

   task automatic wait_idle();
      while (rx_stream_q.size() != 0 || req_valid || due_rsp_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [31:0] v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= v;
      case (idx)
         bld_pkg::CSR_DEST_BASE:    m_dest_base = v;
         bld_pkg::CSR_TOTAL_LEN:    m_total_len = v;
         bld_pkg::CSR_SCRATCH_BASE: m_scr_base = v;
         default:                   m_scr_len = v;
      endcase
   endtask

   task automatic set_regs(logic [31:0] db, logic [31:0] tl, logic [31:0] sb, logic [31:0] sl);
      write_csr(bld_pkg::CSR_DEST_BASE, db);
      write_csr(bld_pkg::CSR_TOTAL_LEN, tl);
      write_csr(bld_pkg::CSR_SCRATCH_BASE, sb);
      write_csr(bld_pkg::CSR_SCRATCH_LEN, sl);
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_type = 1'b0;
      req_rx_byte = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      set_regs(32'h0000_1000, 32'h0010_0000, 32'h8000_0000, 32'h0001_0000);
      // directed: byte extremes, long raw length, bad type, oversize length
      stim_sum = 0;
      put_block(CH_U, 2, 2, 1'b0);
      put(1'b0, 8'hFF);
      put(1'b0, 8'h00);
      stim_sum = 32'hFF;
      put_block(CH_C, 1, 65536, 1'b1);
      put_close(1'b0);
      put_block(8'h58, 1, 1, 1'b0);
      put_drain();
      put_block(CH_U, 32'hFFFF_FFFF, 0, 1'b0);
      put_drain();
      put(1'b0, CH_E);
      put_word(0);
      gen_random(250);
      wait_idle();

      // address wrap, widest limits
      set_regs(32'hFFFF_FFF8, 32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'hFFFF_FFFF);
      stim_sum = 0;
      for (int i = 0; i < 6; i++) put_block(CH_C, 0, 0, 1'b0);
      put_close(1'b0);
      gen_random(100);
      wait_idle();

      // nothing to load: bytes are ignored
      set_regs(32'h0, 32'h0, 32'h0, 32'h0);
      gen_random(30);
      wait_idle();

      // tight scratch area, with a long result stall
      set_regs(32'h0, 32'hFFFF_FFFF, 32'h0000_4000, 32'd20);
      long_hold_req = 1'b1;
      gen_random(200);
      wait_idle();

      // small remaining length so the load completes
      set_regs(32'h2000_0000, m_coff[31:0] + 32'd40, 32'h0, 32'h0000_0100);
      gen_random(150);
      wait_idle();

      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
`default_nettype wire
